// File: hdl/sdh_pkg.sv
// Shared types, constants and helper functions of the size and date histogram.
package sdh_pkg;

   localparam int unsigned SIZE_CLASSES_DEF = 256;
   localparam int unsigned DATE_CLASSES_DEF = 1024;
   localparam int unsigned QUEUE_DEPTH_DEF  = 2;

   // Class numbers are carried at the width of the largest supported class count.
   localparam int unsigned CLS_W = 12;

   localparam int unsigned STEP_W = 23;
   localparam logic [STEP_W-1:0] SIZE_STEP = 23'd5242880;
   localparam logic [STEP_W-1:0] DATE_STEP = 23'd2629800;

   // A size class is 5 MiB: a shift by 20 followed by a divide by five.
   localparam int unsigned SIZE_SHIFT = 20;
   localparam logic [2:0]  SIZE_DIV   = 3'd5;

   localparam logic [1:0] REQ_ADD       = 2'd0;
   localparam logic [1:0] REQ_READ_SIZE = 2'd1;
   localparam logic [1:0] REQ_READ_DATE = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_CHILD = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SKIP,
      OP_READ_SIZE,
      OP_READ_DATE,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [39:0]       file_size;
      logic [CLS_W-1:0]  size_cls;
      logic [CLS_W-1:0]  date_cls;
      logic [31:0]       base;
   } entry_type;

   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] count;
   } bin_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == {32{1'b1}}) ? a : a + 32'd1;
   endfunction

endpackage

// File: hdl/sdh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sdh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sdh_front.sv
// Front end: takes a request, works out its size and date classes and queues it.
module sdh_front #(
   parameter int unsigned SIZE_CLASSES = 256,
   parameter int unsigned DATE_CLASSES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [1:0]          req_type,
   input  logic                req_is_child,
   input  logic [39:0]         req_file_size,
   input  logic [30:0]         req_mod_time,
   input  logic [9:0]          req_bucket_index,
   output logic                front_busy,
   output logic                push,
   output sdh_pkg::entry_type  push_data,
   input  logic                full
);
   import sdh_pkg::*;

   // Reciprocals are chosen so that the estimate is exact or one low.
   localparam int unsigned M5_SHIFT = 24;
   localparam logic [21:0] M5 = 22'((64'd1 << M5_SHIFT) / 64'(SIZE_DIV));
   localparam int unsigned MD_SHIFT = 52;
   localparam logic [30:0] MD = 31'((64'd1 << MD_SHIFT) / 64'(DATE_STEP));

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_EST, F_PUSH} fstate_type;

   fstate_type  state_ff, state_in;
   logic [1:0]  type_ff, type_in;
   logic        child_ff, child_in;
   logic [39:0] size_ff, size_in;
   logic [30:0] time_ff, time_in;
   logic [9:0]  idx_ff, idx_in;
   logic [41:0] prod_s_ff, prod_s_in;
   logic [61:0] prod_d_ff, prod_d_in;
   logic [17:0] qs_ff, qs_in;
   logic [20:0] qs5_ff, qs5_in;
   logic [9:0]  qd_ff, qd_in;
   logic [31:0] qdd_ff, qdd_in;
   logic [31:0] base_ff, base_in;

   logic [19:0]       size_hi;
   logic [STEP_W-1:0] step_sel;
   logic [32:0]       base_prod;
   logic [20:0]       rem_s;
   logic [31:0]       rem_d;
   logic [17:0]       qs_fix;
   logic [9:0]        qd_fix;
   logic [CLS_W-1:0]  qs_clamp;
   logic [CLS_W-1:0]  qd_clamp;
   logic              size_idx_ok;
   logic              date_idx_ok;
   op_type            op;

   assign size_hi = size_ff[39:SIZE_SHIFT];

   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      child_in  = child_ff;
      size_in   = size_ff;
      time_in   = time_ff;
      idx_in    = idx_ff;
      prod_s_in = prod_s_ff;
      prod_d_in = prod_d_ff;
      qs_in     = qs_ff;
      qs5_in    = qs5_ff;
      qd_in     = qd_ff;
      qdd_in    = qdd_ff;
      base_in   = base_ff;
      push      = 1'b0;

      step_sel  = (type_ff == REQ_READ_SIZE) ? SIZE_STEP : DATE_STEP;
      base_prod = {23'b0, idx_ff} * {10'b0, step_sel};

      rem_s  = {1'b0, size_hi} - qs5_ff;
      qs_fix = qs_ff + ((rem_s >= 21'(SIZE_DIV)) ? 18'd1 : 18'd0);
      rem_d  = {1'b0, time_ff} - qdd_ff;
      qd_fix = qd_ff + ((rem_d >= {9'b0, DATE_STEP}) ? 10'd1 : 10'd0);

      qs_clamp = (qs_fix > 18'(SIZE_CLASSES - 1)) ? CLS_W'(SIZE_CLASSES - 1) : qs_fix[CLS_W-1:0];
      qd_clamp = ({2'b0, qd_fix} > CLS_W'(DATE_CLASSES - 1)) ?
                 CLS_W'(DATE_CLASSES - 1) : {2'b0, qd_fix};

      size_idx_ok = ({3'b0, idx_ff} < 13'(SIZE_CLASSES));
      date_idx_ok = ({3'b0, idx_ff} < 13'(DATE_CLASSES));

      unique case (type_ff)
         REQ_ADD:       op = child_ff ? OP_SKIP : OP_ADD;
         REQ_READ_SIZE: op = size_idx_ok ? OP_READ_SIZE : OP_BAD;
         REQ_READ_DATE: op = date_idx_ok ? OP_READ_DATE : OP_BAD;
         default:       op = OP_BAD;
      endcase

      push_data.op        = op;
      push_data.file_size = size_ff;
      push_data.size_cls  = (op == OP_READ_SIZE) ? {2'b0, idx_ff} : qs_clamp;
      push_data.date_cls  = (op == OP_READ_DATE) ? {2'b0, idx_ff} : qd_clamp;
      push_data.base      = (op == OP_READ_SIZE || op == OP_READ_DATE) ? base_ff : 32'd0;

      unique case (state_ff)
         F_IDLE: begin
            if (take) begin
               type_in  = req_type;
               child_in = req_is_child;
               size_in  = req_file_size;
               time_in  = req_mod_time;
               idx_in   = req_bucket_index;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_s_in = {22'b0, size_hi} * {20'b0, M5};
            prod_d_in = {31'b0, time_ff} * {31'b0, MD};
            state_in  = F_EST;
         end
         F_EST: begin
            qs_in    = prod_s_ff[41:M5_SHIFT];
            qs5_in   = ({3'b0, prod_s_ff[41:M5_SHIFT]} << 2) + {3'b0, prod_s_ff[41:M5_SHIFT]};
            qd_in    = prod_d_ff[61:MD_SHIFT];
            qdd_in   = 32'({23'b0, prod_d_ff[61:MD_SHIFT]} * {10'b0, DATE_STEP});
            base_in  = base_prod[32] ? 32'hFFFF_FFFF : base_prod[31:0];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff  <= state_in;
         type_ff   <= type_in;
         child_ff  <= child_in;
         size_ff   <= size_in;
         time_ff   <= time_in;
         idx_ff    <= idx_in;
         prod_s_ff <= prod_s_in;
         prod_d_ff <= prod_d_in;
         qs_ff     <= qs_in;
         qs5_ff    <= qs5_in;
         qd_ff     <= qd_in;
         qdd_ff    <= qdd_in;
         base_ff   <= base_in;
      end
   end

   assign front_busy = (state_ff != F_IDLE);

endmodule

// File: hdl/sdh_queue.sv
// Short FIFO of classified requests between the front end and the back end.
module sdh_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdh_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output sdh_pkg::entry_type head
);
   import sdh_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");

endmodule

// File: hdl/sdh_back.sv
// Back end: clears the class memories, then updates or reads them per queued request.
module sdh_back #(
   parameter int unsigned SIZE_CLASSES = 256,
   parameter int unsigned DATE_CLASSES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  sdh_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_bucket_base,
   output logic [63:0]        rsp_sum_bytes,
   output logic [31:0]        rsp_item_count
);
   import sdh_pkg::*;

   localparam int unsigned SAW = $clog2(SIZE_CLASSES);
   localparam int unsigned DAW = $clog2(DATE_CLASSES);
   localparam int unsigned MAX_CLASSES = (SIZE_CLASSES > DATE_CLASSES) ? SIZE_CLASSES : DATE_CLASSES;
   localparam int unsigned CLR_W = $clog2(MAX_CLASSES);
   localparam int unsigned BIN_W = $bits(bin_type);

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPD} bstate_type;

   bstate_type       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   entry_type        cur_ff, cur_in;
   logic [63:0]      total_ff, total_in;
   logic [31:0]      docs_ff, docs_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      base_ff, base_in;
   logic [63:0]      sum_ff, sum_in;
   logic [31:0]      cnt_ff, cnt_in;

   logic             s_we, d_we;
   logic [SAW-1:0]   s_wa, s_ra;
   logic [DAW-1:0]   d_wa, d_ra;
   bin_type          s_wd, d_wd, s_rd, d_rd;
   logic [BIN_W-1:0] s_rd_raw, d_rd_raw;
   logic [63:0]      size64;

   assign s_rd   = bin_type'(s_rd_raw);
   assign d_rd   = bin_type'(d_rd_raw);
   assign size64 = {24'b0, cur_ff.file_size};
   assign s_ra   = q_head.size_cls[SAW-1:0];
   assign d_ra   = q_head.date_cls[DAW-1:0];

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      total_in  = total_ff;
      docs_in   = docs_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      base_in   = base_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      s_we      = 1'b0;
      d_we      = 1'b0;
      s_wa      = cur_ff.size_cls[SAW-1:0];
      d_wa      = cur_ff.date_cls[DAW-1:0];
      s_wd      = '0;
      d_wd      = '0;

      unique case (state_ff)
         B_CLEAR: begin
            // One entry of each memory is zeroed per cycle after reset, until that memory is cleared.
            s_we = ({1'b0, clr_ff} < (CLR_W + 1)'(SIZE_CLASSES));
            d_we = ({1'b0, clr_ff} < (CLR_W + 1)'(DATE_CLASSES));
            s_wa = clr_ff[SAW-1:0];
            d_wa = clr_ff[DAW-1:0];
            if (clr_ff == CLR_W'(MAX_CLASSES - 1)) begin
               state_in = B_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = B_UPD;
            end
         end
         B_UPD: begin
            strobe_in = 1'b1;
            base_in   = 32'd0;
            sum_in    = 64'd0;
            cnt_in    = 32'd0;
            status_in = STATUS_DONE;
            case (cur_ff.op)
               OP_ADD: begin
                  s_we        = 1'b1;
                  d_we        = 1'b1;
                  s_wd.sum    = sat_add64(s_rd.sum, size64);
                  s_wd.count  = sat_inc32(s_rd.count);
                  d_wd.sum    = sat_add64(d_rd.sum, size64);
                  d_wd.count  = sat_inc32(d_rd.count);
                  total_in    = sat_add64(total_ff, size64);
                  docs_in     = sat_inc32(docs_ff);
                  sum_in      = sat_add64(total_ff, size64);
                  cnt_in      = sat_inc32(docs_ff);
               end
               OP_SKIP: begin
                  status_in = STATUS_CHILD;
                  sum_in    = total_ff;
                  cnt_in    = docs_ff;
               end
               OP_READ_SIZE: begin
                  base_in = cur_ff.base;
                  sum_in  = s_rd.sum;
                  cnt_in  = s_rd.count;
               end
               OP_READ_DATE: begin
                  base_in = cur_ff.base;
                  sum_in  = d_rd.sum;
                  cnt_in  = d_rd.count;
               end
               default: status_in = STATUS_RANGE;
            endcase
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_CLEAR;
         clr_ff    <= '0;
         total_ff  <= '0;
         docs_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         total_ff  <= total_in;
         docs_ff   <= docs_in;
         strobe_ff <= strobe_in;
         cur_ff    <= cur_in;
         status_ff <= status_in;
         base_ff   <= base_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
      end
   end

   sdh_ram #(.WIDTH(BIN_W), .DEPTH(SIZE_CLASSES)) u_size_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wa),
      .wr_data (s_wd),
      .rd_addr (s_ra),
      .rd_data (s_rd_raw)
   );

   sdh_ram #(.WIDTH(BIN_W), .DEPTH(DATE_CLASSES)) u_date_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_wa),
      .wr_data (d_wd),
      .rd_addr (d_ra),
      .rd_data (d_rd_raw)
   );

   assign clearing        = (state_ff == B_CLEAR);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_bucket_base = base_ff;
   assign rsp_sum_bytes   = sum_ff;
   assign rsp_item_count  = cnt_ff;

   assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == B_UPD))
      else $error("result strobe without a completed update");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> (q_empty && !strobe_ff))
      else $error("request traffic during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff) && docs_ff >= $past(docs_ff)))
      else $error("running totals decreased");

endmodule

// File: hdl/size_and_date_histogram.sv
// Top level of the size and date histogram: front end, request queue and back end.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start & !busy             req_type, req_is_child, req_file_size,
//                                                  req_mod_time, req_bucket_index
//   response  out        rsp_strobe, one cycle     rsp_status, rsp_bucket_base,
//                                                  rsp_sum_bytes, rsp_item_count
//
// The front end takes a request only once it has queued the last; its class divides use a
// multiply stage, an estimate stage and a correction stage. The back end pops a request
// when idle, then updates both class memories for an add or reads one, so the queue never
// holds more than one request. Each request passes the multiply, estimate and push states,
// the queue and the idle and update states. After reset busy stays high while the memories
// are cleared one entry per cycle. The response side cannot stall.
module size_and_date_histogram #(
   parameter int unsigned SIZE_CLASSES = sdh_pkg::SIZE_CLASSES_DEF,
   parameter int unsigned DATE_CLASSES = sdh_pkg::DATE_CLASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic        req_is_child,
   input  logic [39:0] req_file_size,
   input  logic [30:0] req_mod_time,
   input  logic [9:0]  req_bucket_index,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_bucket_base,
   output logic [63:0] rsp_sum_bytes,
   output logic [31:0] rsp_item_count
);
   import sdh_pkg::*;

   logic      take;
   logic      front_busy;
   logic      clearing;
   logic      push;
   logic      full;
   logic      pop;
   logic      empty;
   entry_type push_data;
   entry_type head;

   assign busy = front_busy | clearing;
   assign take = start & ~busy;

   sdh_front #(.SIZE_CLASSES(SIZE_CLASSES), .DATE_CLASSES(DATE_CLASSES)) u_front (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .req_type         (req_type),
      .req_is_child     (req_is_child),
      .req_file_size    (req_file_size),
      .req_mod_time     (req_mod_time),
      .req_bucket_index (req_bucket_index),
      .front_busy       (front_busy),
      .push             (push),
      .push_data        (push_data),
      .full             (full)
   );

   sdh_queue #(.DEPTH(QUEUE_DEPTH_DEF)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   sdh_back #(.SIZE_CLASSES(SIZE_CLASSES), .DATE_CLASSES(DATE_CLASSES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_head          (head),
      .q_pop           (pop),
      .clearing        (clearing),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_bucket_base (rsp_bucket_base),
      .rsp_sum_bytes   (rsp_sum_bytes),
      .rsp_item_count  (rsp_item_count)
   );

endmodule
